/* rtl/ets_pkg.sv */
// Shared types, constants and scan functions for the expression token scanner.
package ets_pkg;

  // Width of the position, line and column counters.
  localparam int POS_BITS = 16;
  // Width of the position fields in a result word.
  localparam int OUT_BITS = 16;
  // Result words reserved per input word; one input word causes at most four.
  localparam int MAX_RES = 5;
  // Result queue depth and pointer width.
  localparam int Q_DEPTH = 8;
  localparam int Q_AW = $clog2(Q_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [OUT_BITS-1:0] opos_t;

  // Scanner modes.
  localparam logic [3:0] MODE_IDLE       = 4'd0;
  localparam logic [3:0] MODE_LINE       = 4'd1;
  localparam logic [3:0] MODE_BLOCK_OPEN = 4'd2;
  localparam logic [3:0] MODE_BLOCK      = 4'd3;
  localparam logic [3:0] MODE_SKIP1      = 4'd4;
  localparam logic [3:0] MODE_NUM_INT    = 4'd5;
  localparam logic [3:0] MODE_NUM_FRAC   = 4'd6;
  localparam logic [3:0] MODE_NUM_EXP    = 4'd7;
  localparam logic [3:0] MODE_NUM_SIGN   = 4'd8;
  localparam logic [3:0] MODE_NUM_EXPD   = 4'd9;
  localparam logic [3:0] MODE_STR        = 4'd10;
  localparam logic [3:0] MODE_STR_ESC    = 4'd11;
  localparam logic [3:0] MODE_IDENT      = 4'd12;

  // Token kinds.
  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_STRING = 5'd1;
  localparam logic [4:0] KIND_IDENT  = 5'd2;
  localparam logic [4:0] KIND_TRUE   = 5'd3;
  localparam logic [4:0] KIND_FALSE  = 5'd4;
  localparam logic [4:0] KIND_LPAREN = 5'd5;
  localparam logic [4:0] KIND_RPAREN = 5'd6;
  localparam logic [4:0] KIND_LBRACK = 5'd7;
  localparam logic [4:0] KIND_RBRACK = 5'd8;
  localparam logic [4:0] KIND_COMMA  = 5'd9;
  localparam logic [4:0] KIND_DOT    = 5'd10;
  localparam logic [4:0] KIND_ARROW  = 5'd11;
  localparam logic [4:0] KIND_PLUS   = 5'd12;
  localparam logic [4:0] KIND_MINUS  = 5'd13;
  localparam logic [4:0] KIND_STAR   = 5'd14;
  localparam logic [4:0] KIND_SLASH  = 5'd15;
  localparam logic [4:0] KIND_PCT    = 5'd16;
  localparam logic [4:0] KIND_EQEQ   = 5'd17;
  localparam logic [4:0] KIND_NE     = 5'd18;
  localparam logic [4:0] KIND_LT     = 5'd19;
  localparam logic [4:0] KIND_LE     = 5'd20;
  localparam logic [4:0] KIND_GT     = 5'd21;
  localparam logic [4:0] KIND_GE     = 5'd22;
  localparam logic [4:0] KIND_ANDAND = 5'd23;
  localparam logic [4:0] KIND_OROR   = 5'd24;
  localparam logic [4:0] KIND_BANG   = 5'd25;
  localparam logic [4:0] KIND_QUEST  = 5'd26;
  localparam logic [4:0] KIND_COLON  = 5'd27;
  localparam logic [4:0] KIND_EOF    = 5'd28;

  // Error codes.
  localparam logic [2:0] ERR_BAD_EXP   = 3'd0;
  localparam logic [2:0] ERR_UNTERM    = 3'd1;
  localparam logic [2:0] ERR_LONE_EQ   = 3'd2;
  localparam logic [2:0] ERR_LONE_AMP  = 3'd3;
  localparam logic [2:0] ERR_LONE_BAR  = 3'd4;
  localparam logic [2:0] ERR_UNEXPECT  = 3'd5;

  // ASCII bytes the scanner looks for.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // Keyword spellings as the last identifier bytes, oldest byte on top.
  localparam logic [31:0] KW_TRUE  = 32'h74727565;
  localparam logic [39:0] KW_FALSE = 40'h66616C7365;

  // Scanner state.
  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  la_byte;
    logic        la_valid;
    pos_t        pos;
    pos_t        line;
    pos_t        col;
    pos_t        tpos;
    pos_t        tline;
    pos_t        tcol;
    logic [39:0] kw;
    logic [2:0]  ilen;
  } scan_state_t;

  // One result word.
  typedef struct packed {
    logic       is_error;
    logic [4:0] token_kind;
    logic [2:0] error_code;
    opos_t      start_pos;
    opos_t      end_pos;
    opos_t      start_line;
    opos_t      start_col;
    logic       last_result;
  } res_t;

  // Outcome of scanning one byte: new state and up to two results.
  typedef struct packed {
    scan_state_t st;
    res_t [1:0]  res;
    logic [1:0]  cnt;
  } scan_ret_t;

  // All results caused by one input word.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [2:0]         cnt;
  } batch_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [Q_AW:0] level;
  } q_stat_t;

  function automatic scan_state_t state_reset();
    scan_state_t s;
    s = '0;
    s.mode  = MODE_IDLE;
    s.line  = pos_t'(1);
    s.col   = pos_t'(1);
    s.tline = pos_t'(1);
    s.tcol  = pos_t'(1);
    return s;
  endfunction

  function automatic pos_t sat_inc(pos_t v);
    return (v == '1) ? v : pos_t'(v + 1'b1);
  endfunction

  function automatic scan_state_t consume(scan_state_t s_in, logic [7:0] c);
    scan_state_t s;
    s = s_in;
    if (c == CH_LF) begin
      s.line = sat_inc(s.line);
      s.col  = pos_t'(1);
    end else begin
      s.col = sat_inc(s.col);
    end
    s.pos = sat_inc(s.pos);
    return s;
  endfunction

  function automatic scan_state_t mark(scan_state_t s_in);
    scan_state_t s;
    s = s_in;
    s.tpos  = s.pos;
    s.tline = s.line;
    s.tcol  = s.col;
    return s;
  endfunction

  function automatic res_t make_res(logic err, logic [4:0] kind, logic [2:0] code,
                                    pos_t sp, pos_t ep, pos_t sl, pos_t sc, logic last);
    res_t r;
    r.is_error    = err;
    r.token_kind  = kind;
    r.error_code  = code;
    r.start_pos   = opos_t'(sp);
    r.end_pos     = opos_t'(ep);
    r.start_line  = opos_t'(sl);
    r.start_col   = opos_t'(sc);
    r.last_result = last;
    return r;
  endfunction

  function automatic res_t tok_out(scan_state_t s, logic [4:0] kind);
    return make_res(1'b0, kind, ERR_BAD_EXP, s.tpos, s.pos, s.tline, s.tcol, 1'b0);
  endfunction

  function automatic res_t tok_err(scan_state_t s, logic [2:0] code);
    return make_res(1'b1, KIND_NUMBER, code, s.tpos, s.tpos, s.tline, s.tcol, 1'b0);
  endfunction

  function automatic res_t ident_out(scan_state_t s);
    logic [4:0] kind;
    kind = KIND_IDENT;
    if (s.ilen == 3'd4 && s.kw[31:0] == KW_TRUE) begin
      kind = KIND_TRUE;
    end else if (s.ilen == 3'd5 && s.kw == KW_FALSE) begin
      kind = KIND_FALSE;
    end
    return tok_out(s, kind);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_id_start(logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           (c == CH_UNDER) || (c == CH_DOLLAR);
  endfunction

  // A byte seen between tokens: blanks, comment openers, token starts, punctuators.
  function automatic scan_ret_t idle_byte(scan_state_t s_in, logic [7:0] c,
                                          logic has_n, logic [7:0] n);
    scan_ret_t  r;
    scan_state_t s;
    logic       has_kind;
    logic       has_pair;
    logic [4:0] kind;
    logic [4:0] pair;
    logic [2:0] err;
    logic [7:0] second;
    s = s_in;
    r.res = '0;
    r.cnt = 2'd0;
    has_kind = 1'b0;
    has_pair = 1'b0;
    kind = KIND_NUMBER;
    pair = KIND_NUMBER;
    err = ERR_UNEXPECT;
    second = CH_NUL;
    s.mode = MODE_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      s = consume(s, c);
    end else if (c == CH_SLASH && has_n && n == CH_SLASH) begin
      s = consume(s, c);
      s.mode = MODE_LINE;
    end else if (c == CH_SLASH && has_n && n == CH_STAR) begin
      s = consume(s, c);
      s.mode = MODE_BLOCK_OPEN;
    end else if (is_digit(c)) begin
      s = consume(mark(s), c);
      s.mode = MODE_NUM_INT;
    end else if (c == CH_DQUOTE) begin
      s = consume(mark(s), c);
      s.mode = MODE_STR;
    end else if (is_id_start(c)) begin
      s = consume(mark(s), c);
      s.kw = {32'd0, c};
      s.ilen = 3'd1;
      s.mode = MODE_IDENT;
    end else begin
      // Punctuator table: single kind, paired kind and its second byte.
      s = mark(s);
      case (c)
        CH_LPAREN: begin has_kind = 1'b1; kind = KIND_LPAREN; end
        CH_RPAREN: begin has_kind = 1'b1; kind = KIND_RPAREN; end
        CH_LBRACK: begin has_kind = 1'b1; kind = KIND_LBRACK; end
        CH_RBRACK: begin has_kind = 1'b1; kind = KIND_RBRACK; end
        CH_COMMA:  begin has_kind = 1'b1; kind = KIND_COMMA; end
        CH_DOT:    begin has_kind = 1'b1; kind = KIND_DOT; end
        CH_PLUS:   begin has_kind = 1'b1; kind = KIND_PLUS; end
        CH_STAR:   begin has_kind = 1'b1; kind = KIND_STAR; end
        CH_SLASH:  begin has_kind = 1'b1; kind = KIND_SLASH; end
        CH_PCT:    begin has_kind = 1'b1; kind = KIND_PCT; end
        CH_QUEST:  begin has_kind = 1'b1; kind = KIND_QUEST; end
        CH_COLON:  begin has_kind = 1'b1; kind = KIND_COLON; end
        CH_MINUS: begin
          has_kind = 1'b1; kind = KIND_MINUS;
          has_pair = 1'b1; pair = KIND_ARROW; second = CH_GT;
        end
        CH_LT: begin
          has_kind = 1'b1; kind = KIND_LT;
          has_pair = 1'b1; pair = KIND_LE; second = CH_EQ;
        end
        CH_GT: begin
          has_kind = 1'b1; kind = KIND_GT;
          has_pair = 1'b1; pair = KIND_GE; second = CH_EQ;
        end
        CH_BANG: begin
          has_kind = 1'b1; kind = KIND_BANG;
          has_pair = 1'b1; pair = KIND_NE; second = CH_EQ;
        end
        CH_EQ: begin
          has_pair = 1'b1; pair = KIND_EQEQ; second = CH_EQ; err = ERR_LONE_EQ;
        end
        CH_AMP: begin
          has_pair = 1'b1; pair = KIND_ANDAND; second = CH_AMP; err = ERR_LONE_AMP;
        end
        CH_BAR: begin
          has_pair = 1'b1; pair = KIND_OROR; second = CH_BAR; err = ERR_LONE_BAR;
        end
        default: begin
          has_kind = 1'b0;
        end
      endcase
      r.cnt = 2'd1;
      if (has_pair && has_n && n == second) begin
        // Two-byte operator: its span ends after the second byte, which is skipped.
        s = consume(s, c);
        r.res[0] = make_res(1'b0, pair, ERR_BAD_EXP, s.tpos, sat_inc(s.pos),
                            s.tline, s.tcol, 1'b0);
        s.mode = MODE_SKIP1;
      end else if (has_kind) begin
        s = consume(s, c);
        r.res[0] = tok_out(s, kind);
      end else begin
        r.res[0] = tok_err(s, err);
        s = consume(s, c);
      end
    end
    r.st = s;
    return r;
  endfunction

  // Scan one byte with its optional lookahead byte.
  function automatic scan_ret_t scan_byte(scan_state_t s_in, logic [7:0] c,
                                          logic has_n, logic [7:0] n);
    scan_ret_t   r;
    scan_ret_t   ir;
    scan_state_t s;
    logic        redo;
    s = s_in;
    r.res = '0;
    r.cnt = 2'd0;
    redo = 1'b0;
    case (s.mode)
      MODE_LINE: begin
        if (c == CH_LF) s.mode = MODE_IDLE;
        s = consume(s, c);
      end
      MODE_BLOCK_OPEN: begin
        s = consume(s, c);
        s.mode = MODE_BLOCK;
      end
      MODE_BLOCK: begin
        if (c == CH_STAR && has_n && n == CH_SLASH) s.mode = MODE_SKIP1;
        s = consume(s, c);
      end
      MODE_SKIP1: begin
        s = consume(s, c);
        s.mode = MODE_IDLE;
      end
      MODE_NUM_INT, MODE_NUM_FRAC: begin
        if (is_digit(c)) begin
          s = consume(s, c);
        end else if (s.mode == MODE_NUM_INT && c == CH_DOT && !(has_n && n == CH_DOT)) begin
          s = consume(s, c);
          s.mode = MODE_NUM_FRAC;
        end else if (c == CH_LE || c == CH_UE) begin
          s = consume(s, c);
          s.mode = MODE_NUM_EXP;
        end else begin
          r.res[0] = tok_out(s, KIND_NUMBER);
          r.cnt = 2'd1;
          redo = 1'b1;
        end
      end
      MODE_NUM_EXP, MODE_NUM_SIGN: begin
        if (s.mode == MODE_NUM_EXP && (c == CH_PLUS || c == CH_MINUS)) begin
          s = consume(s, c);
          s.mode = MODE_NUM_SIGN;
        end else if (is_digit(c)) begin
          s = consume(s, c);
          s.mode = MODE_NUM_EXPD;
        end else begin
          r.res[0] = tok_err(s, ERR_BAD_EXP);
          r.cnt = 2'd1;
          s = consume(s, c);
          s.mode = MODE_IDLE;
        end
      end
      MODE_NUM_EXPD: begin
        if (is_digit(c)) begin
          s = consume(s, c);
        end else begin
          r.res[0] = tok_out(s, KIND_NUMBER);
          r.cnt = 2'd1;
          redo = 1'b1;
        end
      end
      MODE_STR: begin
        if (c == CH_DQUOTE) begin
          s = consume(s, c);
          r.res[0] = tok_out(s, KIND_STRING);
          r.cnt = 2'd1;
          s.mode = MODE_IDLE;
        end else begin
          if (c == CH_BSLASH && has_n && n != CH_NUL) s.mode = MODE_STR_ESC;
          s = consume(s, c);
        end
      end
      MODE_STR_ESC: begin
        s = consume(s, c);
        s.mode = MODE_STR;
      end
      MODE_IDENT: begin
        if (is_id_start(c) || is_digit(c)) begin
          s = consume(s, c);
          s.kw = {s.kw[31:0], c};
          if (s.ilen < 3'd6) s.ilen = 3'(s.ilen + 1'b1);
        end else begin
          r.res[0] = ident_out(s);
          r.cnt = 2'd1;
          redo = 1'b1;
        end
      end
      default: begin
        redo = 1'b1;
      end
    endcase
    // A closed token or the idle mode hands the byte to the between-token logic.
    if (redo) begin
      ir = idle_byte(s, c, has_n, n);
      s = ir.st;
      if (ir.cnt != 2'd0) begin
        r.res[r.cnt[0]] = ir.res[0];
        r.cnt = 2'(r.cnt + 1'b1);
      end
    end
    r.st = s;
    return r;
  endfunction

endpackage

/* rtl/ets_in_if.sv */
// Source byte channel of the expression token scanner.
interface ets_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_source;

  modport source (output valid, data_byte, byte_valid, end_of_source, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_source, output ready);
endinterface

/* rtl/ets_out_if.sv */
// Token and error result channel of the expression token scanner.
interface ets_out_if;
  logic        valid;
  logic        ready;
  logic        is_error;
  logic [4:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic [15:0] start_line;
  logic [15:0] start_col;
  logic        last_result;

  modport source (output valid, is_error, token_kind, error_code, start_pos, end_pos,
                  start_line, start_col, last_result, input ready);
  modport sink (input valid, is_error, token_kind, error_code, start_pos, end_pos,
                start_line, start_col, last_result, output ready);
endinterface

/* rtl/ets_scan.sv */
// Scanner state registers and the single-pass logic for one source word.
module ets_scan (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            byte_valid,
  input  logic            end_of_source,
  output ets_pkg::batch_t batch
);

  ets_pkg::scan_state_t state;
  ets_pkg::scan_state_t state_next;

  // Work out every result of the word and the state it leaves.
  always_comb begin
    ets_pkg::scan_state_t s;
    ets_pkg::scan_ret_t   r;
    ets_pkg::batch_t      b;
    s = state;
    r = '0;
    b = '0;
    if (byte_valid) begin
      if (s.la_valid) begin
        r = ets_pkg::scan_byte(s, s.la_byte, 1'b1, data_byte);
        s = r.st;
        for (int j = 0; j < 2; j++) begin
          if (j < int'(r.cnt)) begin
            b.res[b.cnt] = r.res[j];
            b.cnt = 3'(b.cnt + 1'b1);
          end
        end
      end
      s.la_byte = data_byte;
      s.la_valid = 1'b1;
    end
    if (end_of_source) begin
      if (s.la_valid) begin
        r = ets_pkg::scan_byte(s, s.la_byte, 1'b0, ets_pkg::CH_NUL);
        s = r.st;
        for (int j = 0; j < 2; j++) begin
          if (j < int'(r.cnt)) begin
            b.res[b.cnt] = r.res[j];
            b.cnt = 3'(b.cnt + 1'b1);
          end
        end
      end
      // Close a token still open at the end of the source.
      case (s.mode)
        ets_pkg::MODE_NUM_INT, ets_pkg::MODE_NUM_FRAC, ets_pkg::MODE_NUM_EXPD: begin
          b.res[b.cnt] = ets_pkg::tok_out(s, ets_pkg::KIND_NUMBER);
          b.cnt = 3'(b.cnt + 1'b1);
        end
        ets_pkg::MODE_NUM_EXP, ets_pkg::MODE_NUM_SIGN: begin
          b.res[b.cnt] = ets_pkg::tok_err(s, ets_pkg::ERR_BAD_EXP);
          b.cnt = 3'(b.cnt + 1'b1);
        end
        ets_pkg::MODE_STR, ets_pkg::MODE_STR_ESC: begin
          b.res[b.cnt] = ets_pkg::tok_err(s, ets_pkg::ERR_UNTERM);
          b.cnt = 3'(b.cnt + 1'b1);
        end
        ets_pkg::MODE_IDENT: begin
          b.res[b.cnt] = ets_pkg::ident_out(s);
          b.cnt = 3'(b.cnt + 1'b1);
        end
        default: begin
          b.cnt = b.cnt;
        end
      endcase
      b.res[b.cnt] = ets_pkg::make_res(1'b0, ets_pkg::KIND_EOF, ets_pkg::ERR_BAD_EXP,
                                       s.pos, s.pos, s.line, s.col, 1'b1);
      b.cnt = 3'(b.cnt + 1'b1);
      s = ets_pkg::state_reset();
    end
    state_next = s;
    batch = b;
  end

  // State advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ets_pkg::state_reset();
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule

/* rtl/ets_resq.sv */
// Result queue: takes up to five result words at once, hands out one per cycle while it is popped.
module ets_resq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ets_pkg::batch_t  batch,
  input  logic             pop,
  output ets_pkg::res_t    head,
  output logic             not_empty,
  output ets_pkg::q_stat_t stat
);

  ets_pkg::res_t              mem [ets_pkg::Q_DEPTH];
  logic [ets_pkg::Q_AW-1:0]   wr_ptr;
  logic [ets_pkg::Q_AW-1:0]   rd_ptr;
  logic [ets_pkg::Q_AW:0]     level;
  logic [2:0]                 wcnt;

  assign wcnt      = push ? batch.cnt : 3'd0;
  assign head      = mem[rd_ptr];
  assign not_empty = (level != '0);
  assign stat.level = level;

  // Entries are written in order starting at the write pointer.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ets_pkg::MAX_RES; i++) begin
      if (i < int'(wcnt)) begin
        mem[ets_pkg::Q_AW'(wr_ptr + ets_pkg::Q_AW'(i))] <= batch.res[i];
      end
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= ets_pkg::Q_AW'(wr_ptr + wcnt);
      if (pop) rd_ptr <= ets_pkg::Q_AW'(rd_ptr + 1'b1);
      level <= (ets_pkg::Q_AW+1)'(level + wcnt - {{ets_pkg::Q_AW{1'b0}}, pop});
    end
  end

endmodule

/* rtl/expression_token_scanner.sv */
// Top level of the expression token scanner.
//
//   port    direction  word carries
//   in_ch   sink       data_byte, byte_valid, end_of_source
//   out_ch  source     is_error, token_kind, error_code, spans, last_result
//
// One source word is taken per cycle while in_ch.ready is high; its results are
// written into the result queue as it is taken and leave one per cycle while
// out_ch is ready. A word gives up to four results. in_ch.ready is high while the
// queue holds at most three results, so a word is stalled whenever more wait.
// Reset leaves the scanner between tokens at line 1, column 1.
module expression_token_scanner (
  input  logic      clk,
  input  logic      rst,
  ets_in_if.sink    in_ch,
  ets_out_if.source out_ch
);

  logic             take;
  logic             pop;
  logic             not_empty;
  ets_pkg::batch_t  batch;
  ets_pkg::res_t    head;
  ets_pkg::q_stat_t stat;

  // Room for a full batch of results.
  assign in_ch.ready = (stat.level <= (ets_pkg::Q_AW+1)'(ets_pkg::Q_DEPTH - ets_pkg::MAX_RES));
  assign take = in_ch.valid && in_ch.ready;
  assign pop  = out_ch.valid && out_ch.ready;

  ets_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (in_ch.data_byte),
    .byte_valid    (in_ch.byte_valid),
    .end_of_source (in_ch.end_of_source),
    .batch         (batch)
  );

  ets_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .batch     (batch),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .stat      (stat)
  );

  // Output word comes straight from the queue head.
  assign out_ch.valid       = not_empty;
  assign out_ch.is_error    = head.is_error;
  assign out_ch.token_kind  = head.token_kind;
  assign out_ch.error_code  = head.error_code;
  assign out_ch.start_pos   = head.start_pos;
  assign out_ch.end_pos     = head.end_pos;
  assign out_ch.start_line  = head.start_line;
  assign out_ch.start_col   = head.start_col;
  assign out_ch.last_result = head.last_result;

  // Input is refused whenever the queue lacks room for a full batch.
  assert property (@(posedge clk) disable iff (rst)
    (stat.level > (ets_pkg::Q_AW+1)'(ets_pkg::Q_DEPTH - ets_pkg::MAX_RES)) |-> !in_ch.ready)
    else $error("input accepted with no room for a full batch");

  // The end-of-source marker is an Eof token with an empty span.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_result) |->
      (!out_ch.is_error && out_ch.token_kind == ets_pkg::KIND_EOF &&
       out_ch.end_pos == out_ch.start_pos))
    else $error("last result is not an empty Eof token");

  // Errors carry the Number kind code, an empty span and no last-result flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_error) |->
      (out_ch.token_kind == ets_pkg::KIND_NUMBER && out_ch.end_pos == out_ch.start_pos &&
       !out_ch.last_result))
    else $error("malformed error result");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_ch.valid)
    else $error("result offered right after reset");

endmodule

/* dv/tb_expression_token_scanner_if.sv */
// Interfaces are provided by the RTL; this file holds shared testbench types.
`timescale 1ns / 100ps
package tb_ets_types_pkg;

  // One source word as the testbench sends it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_source;
  } src_word_t;
endpackage

/* dv/tb_expression_token_scanner.sv */
// Testbench for the expression token scanner: directed and random sources checked against a predictor.
`timescale 1ns / 100ps
module tb_expression_token_scanner;
  import ets_pkg::*;
  import tb_ets_types_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ets_in_if  in_ch ();
  ets_out_if out_ch ();

  expression_token_scanner DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [3:0]  p_mode;
  logic [7:0]  p_la;
  logic        p_la_ok;
  logic [15:0] p_pos, p_line, p_col, p_tpos, p_tline, p_tcol;
  logic [39:0] p_kw;
  logic [2:0]  p_ilen;

  res_t expected_tokens[$];
  int   mismatch_count = 0;
  int   words_sent = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;
  int   stall_left = 0;
  bit   allow_gaps = 1'b1;

  function automatic logic [15:0] sat1(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit id_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
  endfunction

  function automatic void advance(logic [7:0] c);
    if (c == CH_LF) begin
      p_line = sat1(p_line);
      p_col = 16'd1;
    end else begin
      p_col = sat1(p_col);
    end
    p_pos = sat1(p_pos);
  endfunction

  function automatic void start_token();
    p_tpos = p_pos;
    p_tline = p_line;
    p_tcol = p_col;
  endfunction

  function automatic void push_result(logic err, logic [4:0] kind, logic [2:0] code,
                                      logic [15:0] sp, logic [15:0] ep,
                                      logic [15:0] sl, logic [15:0] sc, logic last);
    res_t r;
    r.is_error = err;
    r.token_kind = kind;
    r.error_code = code;
    r.start_pos = sp;
    r.end_pos = ep;
    r.start_line = sl;
    r.start_col = sc;
    r.last_result = last;
    expected_tokens.insert(expected_tokens.size(), r);
  endfunction

  function automatic void emit_token(logic [4:0] kind);
    push_result(1'b0, kind, ERR_BAD_EXP, p_tpos, p_pos, p_tline, p_tcol, 1'b0);
  endfunction

  function automatic void emit_error(logic [2:0] code);
    push_result(1'b1, KIND_NUMBER, code, p_tpos, p_tpos, p_tline, p_tcol, 1'b0);
  endfunction

  function automatic void emit_ident();
    logic [4:0] kind;
    kind = KIND_IDENT;
    if (p_ilen == 3'd4 && p_kw[31:0] == 32'h74727565) kind = KIND_TRUE;
    else if (p_ilen == 3'd5 && p_kw == 40'h66616C7365) kind = KIND_FALSE;
    emit_token(kind);
  endfunction

  function automatic void clear_scanner();
    p_mode = MODE_IDLE;
    p_la = 8'd0;
    p_la_ok = 1'b0;
    p_pos = 16'd0;
    p_line = 16'd1;
    p_col = 16'd1;
    p_tpos = 16'd0;
    p_tline = 16'd1;
    p_tcol = 16'd1;
    p_kw = 40'd0;
    p_ilen = 3'd0;
  endfunction

  // Punctuator between tokens, with its possible two-byte form.
  function automatic void scan_punct(logic [7:0] c, bit has_n, logic [7:0] n);
    logic [4:0] kind, pair;
    logic [2:0] err;
    logic [7:0] second;
    bit has_kind, has_pair;
    has_kind = 1'b1;
    has_pair = 1'b0;
    kind = KIND_NUMBER;
    pair = KIND_NUMBER;
    err = ERR_UNEXPECT;
    second = 8'd0;
    start_token();
    case (c)
      "(": kind = KIND_LPAREN;
      ")": kind = KIND_RPAREN;
      "[": kind = KIND_LBRACK;
      "]": kind = KIND_RBRACK;
      ",": kind = KIND_COMMA;
      ".": kind = KIND_DOT;
      "+": kind = KIND_PLUS;
      "*": kind = KIND_STAR;
      "/": kind = KIND_SLASH;
      "%": kind = KIND_PCT;
      "?": kind = KIND_QUEST;
      ":": kind = KIND_COLON;
      "-": begin kind = KIND_MINUS; has_pair = 1; pair = KIND_ARROW; second = ">"; end
      "<": begin kind = KIND_LT; has_pair = 1; pair = KIND_LE; second = "="; end
      ">": begin kind = KIND_GT; has_pair = 1; pair = KIND_GE; second = "="; end
      "!": begin kind = KIND_BANG; has_pair = 1; pair = KIND_NE; second = "="; end
      "=": begin has_kind = 0; has_pair = 1; pair = KIND_EQEQ; second = "="; err = ERR_LONE_EQ; end
      "&": begin has_kind = 0; has_pair = 1; pair = KIND_ANDAND; second = "&"; err = ERR_LONE_AMP; end
      "|": begin has_kind = 0; has_pair = 1; pair = KIND_OROR; second = "|"; err = ERR_LONE_BAR; end
      default: has_kind = 1'b0;
    endcase
    if (has_pair && has_n && n == second) begin
      advance(c);
      push_result(1'b0, pair, ERR_BAD_EXP, p_tpos, sat1(p_pos), p_tline, p_tcol, 1'b0);
      p_mode = MODE_SKIP1;
    end else if (has_kind) begin
      advance(c);
      emit_token(kind);
    end else begin
      emit_error(err);
      advance(c);
    end
  endfunction

  // Scan one byte with its optional lookahead.
  function automatic void scan_char(logic [7:0] c, bit has_n, logic [7:0] n);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (p_mode)
        MODE_LINE: begin
          if (c == CH_LF) p_mode = MODE_IDLE;
          advance(c);
        end
        MODE_BLOCK_OPEN: begin
          advance(c);
          p_mode = MODE_BLOCK;
        end
        MODE_BLOCK: begin
          if (c == "*" && has_n && n == "/") p_mode = MODE_SKIP1;
          advance(c);
        end
        MODE_SKIP1: begin
          advance(c);
          p_mode = MODE_IDLE;
        end
        MODE_NUM_INT, MODE_NUM_FRAC: begin
          if (digit(c)) advance(c);
          else if (p_mode == MODE_NUM_INT && c == "." && !(has_n && n == ".")) begin
            advance(c);
            p_mode = MODE_NUM_FRAC;
          end else if (c == "e" || c == "E") begin
            advance(c);
            p_mode = MODE_NUM_EXP;
          end else begin
            emit_token(KIND_NUMBER);
            p_mode = MODE_IDLE;
            again = 1'b1;
          end
        end
        MODE_NUM_EXP, MODE_NUM_SIGN: begin
          if (p_mode == MODE_NUM_EXP && (c == "+" || c == "-")) begin
            advance(c);
            p_mode = MODE_NUM_SIGN;
          end else if (digit(c)) begin
            advance(c);
            p_mode = MODE_NUM_EXPD;
          end else begin
            emit_error(ERR_BAD_EXP);
            advance(c);
            p_mode = MODE_IDLE;
          end
        end
        MODE_NUM_EXPD: begin
          if (digit(c)) advance(c);
          else begin
            emit_token(KIND_NUMBER);
            p_mode = MODE_IDLE;
            again = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == CH_DQUOTE) begin
            advance(c);
            emit_token(KIND_STRING);
            p_mode = MODE_IDLE;
          end else begin
            if (c == CH_BSLASH && has_n && n != 8'd0) p_mode = MODE_STR_ESC;
            advance(c);
          end
        end
        MODE_STR_ESC: begin
          advance(c);
          p_mode = MODE_STR;
        end
        MODE_IDENT: begin
          if (id_char(c) || digit(c)) begin
            advance(c);
            p_kw = {p_kw[31:0], c};
            if (p_ilen < 3'd6) p_ilen = p_ilen + 3'd1;
          end else begin
            emit_ident();
            p_mode = MODE_IDLE;
            again = 1'b1;
          end
        end
        default: begin
          p_mode = MODE_IDLE;
          if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF) advance(c);
          else if (c == "/" && has_n && n == "/") begin
            advance(c);
            p_mode = MODE_LINE;
          end else if (c == "/" && has_n && n == "*") begin
            advance(c);
            p_mode = MODE_BLOCK_OPEN;
          end else if (digit(c)) begin
            start_token();
            advance(c);
            p_mode = MODE_NUM_INT;
          end else if (c == CH_DQUOTE) begin
            start_token();
            advance(c);
            p_mode = MODE_STR;
          end else if (id_char(c)) begin
            start_token();
            advance(c);
            p_kw = {32'd0, c};
            p_ilen = 3'd1;
            p_mode = MODE_IDENT;
          end else begin
            scan_punct(c, has_n, n);
          end
        end
      endcase
    end
  endfunction

  // Work out the results that one accepted source word causes.
  function automatic void predict_tokens(src_word_t w);
    if (w.byte_valid) begin
      if (p_la_ok) scan_char(p_la, 1'b1, w.data_byte);
      p_la = w.data_byte;
      p_la_ok = 1'b1;
    end
    if (w.end_of_source) begin
      if (p_la_ok) scan_char(p_la, 1'b0, 8'd0);
      case (p_mode)
        MODE_NUM_INT, MODE_NUM_FRAC, MODE_NUM_EXPD: emit_token(KIND_NUMBER);
        MODE_NUM_EXP, MODE_NUM_SIGN: emit_error(ERR_BAD_EXP);
        MODE_STR, MODE_STR_ESC: emit_error(ERR_UNTERM);
        MODE_IDENT: emit_ident();
        default: ;
      endcase
      push_result(1'b0, KIND_EOF, ERR_BAD_EXP, p_pos, p_pos, p_line, p_col, 1'b1);
      clear_scanner();
    end
  endfunction

  // Send one word, with an occasional random gap before it.
  task automatic send_word(logic [7:0] b, bit bv, bit eos);
    src_word_t w;
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    w.data_byte = b;
    w.byte_valid = bv;
    w.end_of_source = eos;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_valid <= bv;
    in_ch.end_of_source <= eos;
    do @(posedge clk); while (!in_ch.ready);
    predict_tokens(w);
    words_sent++;
  endtask

  task automatic send_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, close && i == s.len() - 1);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  // Result checker and stall generator.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_t got, want;
        got.is_error = out_ch.is_error;
        got.token_kind = out_ch.token_kind;
        got.error_code = out_ch.error_code;
        got.start_pos = out_ch.start_pos;
        got.end_pos = out_ch.end_pos;
        got.start_line = out_ch.start_line;
        got.start_col = out_ch.start_col;
        got.last_result = out_ch.last_result;
        results_seen++;
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result word %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      // Random stalls come in bursts, and only while gaps are allowed.
      if (!allow_gaps) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (out_ch.ready && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_tokens.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_tokens();
    send_text("x1 = true && false||(3.5e+2 ->a[0]) != \"s\\\"t\" // c\n", 1'b0);
    send_text("/* b */ <= >= < > ! ? : , . + - * / % &| @ 1..2 12e; \"open", 1'b1);
  endtask

  task automatic test_empty_and_edges();
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    send_text("\"a\\", 1'b1);
    send_text("9e-", 1'b1);
    send_text("falsey", 1'b1);
    wait_drained();
  endtask

  // Random sources: mostly well-formed fragments, some raw noise.
  task automatic test_random_sources(int count);
    string frags[16] = '{"abc", "true", "false", "42", "3.14", "1e9", "7E-3", " ",
                         "\n", "\"q\\n\"", "// x\n", "/*z*/", "->", "==", "<=", "&&"};
    int sent;
    string s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        sent++;
      end else begin
        s = frags[$urandom_range(0, 15)];
        send_text(s, 1'b0);
        sent += s.len();
      end
      if ($urandom_range(0, 19) == 0) begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end
    end
    send_word(8'h20, 1'b1, 1'b1);
  endtask

  // Long line pushes column counts out.
  task automatic test_long_line();
    for (int i = 0; i < 40; i++) send_word((i % 7 == 6) ? 8'h20 : "k", 1'b1, 1'b0);
    send_word(8'h0A, 1'b1, 1'b1);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.byte_valid = 1'b0;
    in_ch.end_of_source = 1'b0;
    clear_scanner();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_tokens();
    test_empty_and_edges();
    test_random_sources(100);
    wait_drained();
    test_long_line();
    allow_gaps = 1'b0;
    test_random_sources(50);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d source words and checked %0d result words", words_sent, results_seen);
    $display("Covered operators, comments, numbers, strings, keywords and lexical errors");
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/ets_pkg.sv
rtl/ets_in_if.sv
rtl/ets_out_if.sv
rtl/ets_scan.sv
rtl/ets_resq.sv
rtl/expression_token_scanner.sv
dv/tb_expression_token_scanner_if.sv
dv/tb_expression_token_scanner.sv
